FILE: hw/rtl/gtg_pkg.sv
// Shared types and constants for the go-to-goal proportional drive.
// Holds the CORDIC pipeline item, the arctangent table and the register indexes.
// No dependencies.
package gtg_pkg;

  // CORDIC datapath widths: x/y in Q.19, z in Q.28 radians
  localparam int unsigned XW = 28;
  localparam int unsigned ZW = 32;
  localparam int unsigned TABLE_LEN = 24;

  localparam logic signed [ZW-1:0] PI_Q28 = 32'sd843314857;
  // 1/K in Q.30
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  // 0.1 in Q5.11 moved to Q.19
  localparam logic [25:0] DIST_MIN_Q19 = 26'd52480;
  // 0.2 in Q3.12 moved to Q.28
  localparam logic [32:0] ANG_MAX_Q28 = 33'd53673984;
  localparam logic [14:0] SPEED_SAT = 15'h7fff;

  // atan(2^-i) in Q.28
  localparam logic signed [ZW-1:0] ATAN_Q28 [TABLE_LEN] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32
  };

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_TARGET_X  = 3'd0,
    CFG_TARGET_Y  = 3'd1,
    CFG_GAIN      = 3'd2,
    CFG_MAX_SPEED = 3'd3
  } cfg_idx_e;

  // One item travelling down the CORDIC chain
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [15:0]   heading;
  } vec_t;

endpackage

FILE: hw/rtl/go_to_goal_proportional_drive.sv
// Top level of the go-to-goal proportional drive.
// Uses gtg_pkg, gtg_prep, gtg_cordic_cell and gtg_post.
//
// Usage:
//   Pose in: drive pos_x_i, pos_y_i, heading_i and raise start for one cycle
//   per item. busy stays low, so a pose is taken in every cycle that start
//   is high.
//   Command out: done_o pulses for one cycle with linear_speed_o and
//   angular_speed_o valid in that cycle. The receiver cannot stall; it must
//   take the command in that cycle.
//   From start to done_o an item passes one entry cell, one cell per CORDIC
//   micro-rotation and three exit cells (scale, decide, round/clamp).
//   Throughput is one item per cycle, set by the chain of CORDIC cells, each
//   of which registers one micro-rotation.
//   Configuration: cfg_valid_i with cfg_index_i and cfg_data_i writes a
//   register; cfg_ready_o is always high. Indexes beyond max_speed are
//   ignored. Write only while no item is in flight.
//   Reset: rst_ni clears the pipeline valids and loads the targets to 1.0,
//   the gain to 1.0 and max_speed to 3.0. No clearing pass is needed.
module go_to_goal_proportional_drive import gtg_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  output logic               done_o,
  output logic [14:0]        linear_speed_o,
  output logic [14:0]        angular_speed_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic signed [15:0] target_x_q, target_y_q;
  logic [15:0]        gain_q;
  logic [14:0]        max_speed_q;

  vec_t vec_chain   [CORDIC_STAGES+1];
  logic valid_chain [CORDIC_STAGES+1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_x_q  <= 16'sd2048;
      target_y_q  <= 16'sd2048;
      gain_q      <= 16'd4096;
      max_speed_q <= 15'd6144;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TARGET_X:  target_x_q  <= cfg_data_i;
        CFG_TARGET_Y:  target_y_q  <= cfg_data_i;
        CFG_GAIN:      gain_q      <= cfg_data_i;
        CFG_MAX_SPEED: max_speed_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Entry cell
  gtg_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start && !busy),
    .target_x_i (target_x_q),
    .target_y_i (target_y_q),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .heading_i  (heading_i),
    .valid_o    (valid_chain[0]),
    .vec_o      (vec_chain[0])
  );

  // Chain of CORDIC cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    gtg_cordic_cell #(
      .Idx (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_chain[i]),
      .vec_i   (vec_chain[i]),
      .valid_o (valid_chain[i+1]),
      .vec_o   (vec_chain[i+1])
    );
  end

  // Exit cells
  gtg_post u_post (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_chain[CORDIC_STAGES]),
    .vec_i           (vec_chain[CORDIC_STAGES]),
    .gain_i          (gain_q),
    .max_speed_i     (max_speed_q),
    .done_o          (done_o),
    .linear_speed_o  (linear_speed_o),
    .angular_speed_o (angular_speed_o)
  );

`ifndef SYNTHESIS
  // Every accepted pose yields a command after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(CORDIC_STAGES + 4) done_o)
    else $error("command missing after pose");

  // A command never drives and turns at once
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (linear_speed_o == '0 || angular_speed_o == '0))
    else $error("drive and turn both nonzero");

  // Linear speed respects the clamp
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (linear_speed_o <= max_speed_q))
    else $error("linear speed above max_speed");

  // No command without a pose in flight
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(valid_chain[CORDIC_STAGES], 3))
    else $error("command without pose");
`endif

endmodule

FILE: hw/rtl/gtg_prep.sv
// Entry cell: forms the goal offset and folds it into the right half plane.
// Depends on gtg_pkg.
module gtg_prep import gtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  output logic               valid_o,
  output vec_t               vec_o
);

  logic [16:0]          dx, dy;
  logic signed [XW-1:0] x_s, y_s;
  vec_t                 vec_d, vec_q;
  logic                 valid_q;

  // Exact 17-bit differences
  assign dx = {target_x_i[15], target_x_i} - {pos_x_i[15], pos_x_i};
  assign dy = {target_y_i[15], target_y_i} - {pos_y_i[15], pos_y_i};

  // Add guard bits
  assign x_s = $signed({{3{dx[16]}}, dx, 8'b0});
  assign y_s = $signed({{3{dy[16]}}, dy, 8'b0});

  // Negate a left-pointing vector and preload the angle with +/- pi
  always_comb begin
    vec_d.heading = heading_i;
    if (dx[16]) begin
      vec_d.x = -x_s;
      vec_d.y = -y_s;
      vec_d.z = dy[16] ? -PI_Q28 : PI_Q28;
    end else begin
      vec_d.x = x_s;
      vec_d.y = y_s;
      vec_d.z = '0;
    end
  end

  // Advance valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

FILE: hw/rtl/gtg_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its pipeline register.
// Depends on gtg_pkg.
module gtg_cordic_cell import gtg_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  vec_t vec_i,
  output logic valid_o,
  output vec_t vec_o
);

  localparam logic [4:0] TabIdx = 5'(Idx);

  logic signed [XW-1:0] x_in, y_in, xs, ys;
  logic signed [ZW-1:0] z_in;
  vec_t                 vec_d, vec_q;
  logic                 valid_q;

  assign x_in = vec_i.x;
  assign y_in = vec_i.y;
  assign z_in = vec_i.z;

  // Floor shifts
  assign xs = x_in >>> Idx;
  assign ys = y_in >>> Idx;

  // Rotate toward the x axis, accumulate angle
  always_comb begin
    vec_d.heading = vec_i.heading;
    if (!y_in[XW-1]) begin
      vec_d.x = x_in + ys;
      vec_d.y = y_in - xs;
      vec_d.z = z_in + ATAN_Q28[TabIdx];
    end else begin
      vec_d.x = x_in - ys;
      vec_d.y = y_in + xs;
      vec_d.z = z_in - ATAN_Q28[TabIdx];
    end
  end

  // Advance valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

FILE: hw/rtl/gtg_post.sv
// Exit cells: scale the magnitude, form the bearing error and pick the command.
// Three register stages. Depends on gtg_pkg.
module gtg_post import gtg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  vec_t        vec_i,
  input  logic [15:0] gain_i,
  input  logic [14:0] max_speed_i,
  output logic        done_o,
  output logic [14:0] linear_speed_o,
  output logic [14:0] angular_speed_o
);

  // Stage A signals
  logic [56:0] prod_a;
  logic [33:0] err_a;
  logic [32:0] aerr_a;
  logic [25:0] dist_d, dist_q;
  logic [32:0] aerr_d, aerr_q;
  logic        va_q;

  // Stage B signals
  logic [18:0] ang_rnd;
  logic [14:0] ang_d, ang_q;
  logic [41:0] prod_d, prod_q;
  logic        far_d, far_q, turn_d, turn_q;
  logic        vb_q;

  // Stage C signals
  logic [23:0] lin_rnd;
  logic [22:0] lin_raw;
  logic [14:0] lin_clamp;
  logic [14:0] lin_d, lin_q, angc_d, angc_q;
  logic        vc_q;

  // Stage A: distance = x / K, absolute bearing error
  assign prod_a = 57'(vec_i.x[XW-2:0]) * 57'(INV_GAIN_Q30);
  assign dist_d = prod_a[55:30];
  assign err_a  = {{2{vec_i.z[ZW-1]}}, vec_i.z}
                - {{2{vec_i.heading[15]}}, vec_i.heading, 16'b0};
  assign aerr_a = err_a[33] ? 33'(-err_a) : err_a[32:0];
  assign aerr_d = aerr_a;

  // Stage B: thresholds, angle rounding, gain product
  assign far_d   = dist_q > DIST_MIN_Q19;
  assign turn_d  = aerr_q > ANG_MAX_Q28;
  assign ang_rnd = 19'(aerr_q[32:15]) + 19'd1;
  assign ang_d   = (ang_rnd[18:1] > 18'(SPEED_SAT)) ? SPEED_SAT : ang_rnd[15:1];
  assign prod_d  = 42'(gain_i) * 42'(dist_q);

  // Stage C: round the linear speed, clamp, select by case
  assign lin_rnd   = 24'(prod_q[41:19]) + 24'd1;
  assign lin_raw   = lin_rnd[23:1];
  assign lin_clamp = (lin_raw > 23'(max_speed_i)) ? max_speed_i : lin_raw[14:0];
  assign lin_d     = (far_q && !turn_q) ? lin_clamp : '0;
  assign angc_d    = (far_q && turn_q) ? ang_q : '0;

  // Advance valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    aerr_q <= aerr_d;
    far_q  <= far_d;
    turn_q <= turn_d;
    ang_q  <= ang_d;
    prod_q <= prod_d;
    lin_q  <= lin_d;
    angc_q <= angc_d;
  end

  assign done_o          = vc_q;
  assign linear_speed_o  = lin_q;
  assign angular_speed_o = angc_q;

endmodule
